// ----- src/prc_pkg.sv -----
// prc_pkg: shared types and constants for the polar/rectangular converter.
// Holds the arctangent table, gain and angle constants, and the pipeline control struct.
// No dependencies.
package prc_pkg;

   localparam int GUARD_BITS = 8;
   localparam int ANGLE_W    = 32;
   localparam int ATAN_DEPTH = 32;

   typedef enum logic {
      REQ_TO_POLAR = 1'b0,
      REQ_TO_RECT  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic valid;
      logic to_rect;
      logic origin;
   } pipe_ctl_type;

   // inverse CORDIC gain, scaled by 2^32
   localparam logic [31:0] INV_GAIN   = 32'd2608131497;
   localparam logic [31:0] ROUND_HALF = 32'h0080_0000;

   localparam logic [ANGLE_W-1:0]        HALF_TURN    = 32'h8000_0000;
   localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = 32'sh4000_0000;

   // atan(2^-i) in binary angle units, 2^32 per turn
   localparam logic [ANGLE_W-1:0] ATAN_TAB [0:ATAN_DEPTH-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

endpackage

// ----- src/prc_cell.sv -----
// prc_cell: one CORDIC micro-rotation stage with its output register.
// Depends on prc_pkg for the arctangent table and control struct.
module prc_cell
   import prc_pkg::*;
#(
   parameter int XW          = 28,
   parameter int STAGE_INDEX = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  pipe_ctl_type             in_ctl,
   input  logic signed [XW-1:0]     in_x,
   input  logic signed [XW-1:0]     in_y,
   input  logic [ANGLE_W-1:0]       in_z,
   output pipe_ctl_type             out_ctl,
   output logic signed [XW-1:0]     out_x,
   output logic signed [XW-1:0]     out_y,
   output logic [ANGLE_W-1:0]       out_z
);

   localparam logic [ANGLE_W-1:0] ATAN_STEP = ATAN_TAB[STAGE_INDEX];

   pipe_ctl_type          ctl_ff;
   logic signed [XW-1:0]  x_ff, x_in;
   logic signed [XW-1:0]  y_ff, y_in;
   logic [ANGLE_W-1:0]    z_ff, z_in;
   logic signed [XW-1:0]  x_shift;
   logic signed [XW-1:0]  y_shift;
   logic                  rot_pos;

   always_comb begin
      x_shift = in_x >>> STAGE_INDEX;
      y_shift = in_y >>> STAGE_INDEX;
      // vectoring steers on the sign of y, rotation on the sign of z
      rot_pos = in_ctl.to_rect ? ~in_z[ANGLE_W-1] : in_y[XW-1];
      if (rot_pos) begin
         x_in = in_x - y_shift;
         y_in = in_y + x_shift;
         z_in = in_z - ATAN_STEP;
      end else begin
         x_in = in_x + y_shift;
         y_in = in_y - x_shift;
         z_in = in_z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff <= in_ctl;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign out_ctl = ctl_ff;
   assign out_x   = x_ff;
   assign out_y   = y_ff;
   assign out_z   = z_ff;

endmodule

// ----- src/prc_scale.sv -----
// prc_scale: removes the CORDIC gain and the guard bits from one coordinate.
// Three register stages: magnitude, split product, round and restore sign. Uses prc_pkg.
module prc_scale
   import prc_pkg::*;
#(
   parameter int XW = 28
) (
   input  logic                   clock,
   input  logic signed [XW-1:0]   in_value,
   output logic signed [XW-7:0]   out_value
);

   localparam int QW = XW - 6;
   localparam int HW = XW + 16;
   localparam int TW = XW + 17;

   logic              neg1_ff, neg2_ff;
   logic [XW-1:0]     mag_ff, mag_in;
   logic [HW-1:0]     hi_ff, hi_in;
   logic [47:0]       lo_ff, lo_in;
   logic [TW-1:0]     sum;
   logic [TW-1:0]     rounded;
   logic [QW-1:0]     quot;
   logic signed [QW-1:0] res_ff, res_in;

   always_comb begin
      mag_in  = in_value[XW-1] ? XW'(-in_value) : XW'(in_value);
      hi_in   = HW'(mag_ff[XW-1:16]) * HW'(INV_GAIN);
      lo_in   = 48'(mag_ff[15:0]) * 48'(INV_GAIN);
      sum     = TW'(hi_ff) + TW'(lo_ff[47:16]);
      rounded = sum + TW'(ROUND_HALF);
      quot    = QW'(rounded[TW-1:24]);
      res_in  = neg2_ff ? -$signed(quot) : $signed(quot);
   end

   always_ff @(posedge clock) begin
      neg1_ff <= in_value[XW-1];
      mag_ff  <= mag_in;
      neg2_ff <= neg1_ff;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      res_ff  <= res_in;
   end

   assign out_value = res_ff;

endmodule

// ----- src/prc_post.sv -----
// prc_post: output end of the converter; gain removal, angle rounding, clipping.
// Instantiates two prc_scale units; uses prc_pkg.
module prc_post
   import prc_pkg::*;
#(
   parameter int DW = 16,
   parameter int XW = 28
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pipe_ctl_type           in_ctl,
   input  logic signed [XW-1:0]   in_x,
   input  logic signed [XW-1:0]   in_y,
   input  logic [ANGLE_W-1:0]     in_z,
   output logic                   out_strobe,
   output logic signed [DW:0]     out_first,
   output logic signed [DW-1:0]   out_second,
   output logic                   out_saturated
);

   localparam int QW        = XW - 6;
   localparam int DLY       = 3;
   localparam int ANG_SHIFT = ANGLE_W - DW;
   localparam logic [ANGLE_W-1:0] ANG_HALF = (ANGLE_W'(1) << ANG_SHIFT) >> 1;
   localparam logic signed [QW-1:0] S_MAX_Q = {{(QW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [QW-1:0] S_MIN_Q = {{(QW-DW+1){1'b1}}, {(DW-1){1'b0}}};
   localparam logic signed [QW-1:0] U_MAX_Q = {{(QW-DW){1'b0}}, {DW{1'b1}}};

   pipe_ctl_type            ctl_dly_ff [DLY];
   logic [ANGLE_W-1:0]      z_dly_ff   [DLY];
   logic signed [QW-1:0]    qx, qy;
   logic signed [QW-1:0]    x_clip, y_clip, mag_clip;
   logic [ANGLE_W-1:0]      z_round;
   logic                    strobe_ff;
   logic signed [DW:0]      first_ff, first_in;
   logic signed [DW-1:0]    second_ff, second_in;
   logic                    sat_ff, sat_in;
   pipe_ctl_type            ctl_last;

   prc_scale #(.XW(XW)) u_scale_x (
      .clock     (clock),
      .in_value  (in_x),
      .out_value (qx)
   );

   prc_scale #(.XW(XW)) u_scale_y (
      .clock     (clock),
      .in_value  (in_y),
      .out_value (qy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DLY; k++) begin
            ctl_dly_ff[k].valid <= 1'b0;
         end
         strobe_ff <= 1'b0;
      end else begin
         ctl_dly_ff[0] <= in_ctl;
         for (int k = 1; k < DLY; k++) begin
            ctl_dly_ff[k] <= ctl_dly_ff[k-1];
         end
         strobe_ff <= ctl_dly_ff[DLY-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      z_dly_ff[0] <= in_z;
      for (int k = 1; k < DLY; k++) begin
         z_dly_ff[k] <= z_dly_ff[k-1];
      end
      first_ff  <= first_in;
      second_ff <= second_in;
      sat_ff    <= sat_in;
   end

   always_comb begin
      ctl_last = ctl_dly_ff[DLY-1];
      z_round  = z_dly_ff[DLY-1] + ANG_HALF;
      sat_in   = 1'b0;
      x_clip   = qx;
      y_clip   = qy;
      mag_clip = qx;
      if (qx > S_MAX_Q) begin
         x_clip = S_MAX_Q;
      end else if (qx < S_MIN_Q) begin
         x_clip = S_MIN_Q;
      end
      if (qy > S_MAX_Q) begin
         y_clip = S_MAX_Q;
      end else if (qy < S_MIN_Q) begin
         y_clip = S_MIN_Q;
      end
      if (qx > U_MAX_Q) begin
         mag_clip = U_MAX_Q;
      end else if (qx[QW-1]) begin
         mag_clip = '0;
      end
      priority if (ctl_last.to_rect) begin
         sat_in    = (x_clip != qx) || (y_clip != qy);
         first_in  = (DW+1)'(x_clip);
         second_in = DW'(y_clip);
      end else if (ctl_last.origin) begin
         first_in  = '0;
         second_in = '0;
      end else begin
         sat_in    = (mag_clip != qx);
         first_in  = (DW+1)'(mag_clip);
         second_in = z_round[ANGLE_W-1 -: DW];
      end
   end

   assign out_strobe    = strobe_ff;
   assign out_first     = first_ff;
   assign out_second    = second_ff;
   assign out_saturated = sat_ff;

endmodule

// ----- src/polar_rectangular_converter_top.sv -----
// Polar/rectangular converter: pipelined CORDIC, one cell per micro-rotation.
// Pipeline stages: input register, CORDIC_STAGES cells, three gain stages, output
// register; one transfer accepted every cycle.
// busy is high only during reset; results carry no backpressure.
// Synchronous reset clears all valid flags; payload registers are not reset.
// Depends on prc_pkg, prc_cell, prc_scale, prc_post.
module polar_rectangular_converter_top
   import prc_pkg::*;
#(
   parameter int DATA_WIDTH    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic signed [DATA_WIDTH:0]    req_first_value,
   input  logic signed [DATA_WIDTH-1:0]  req_second_value,
   output logic                          rsp_strobe,
   output logic signed [DATA_WIDTH:0]    rsp_first_result,
   output logic signed [DATA_WIDTH-1:0]  rsp_second_result,
   output logic                          rsp_saturated
);

   localparam int DW        = DATA_WIDTH;
   localparam int XW        = DW + GUARD_BITS + 4;
   localparam int ANG_SHIFT = ANGLE_W - DW;
   localparam logic [DW:0]   U_MAX_EXT = {1'b0, {DW{1'b1}}};
   localparam logic [DW:0]   S_MAX_EXT = {2'b00, {(DW-1){1'b1}}};
   localparam logic [DW:0]   S_MIN_EXT = {2'b11, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] S_MAX_SEC = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] S_MIN_SEC = {1'b1, {(DW-1){1'b0}}};

   pipe_ctl_type          chain_ctl [CORDIC_STAGES+1];
   logic signed [XW-1:0]  chain_x   [CORDIC_STAGES+1];
   logic signed [XW-1:0]  chain_y   [CORDIC_STAGES+1];
   logic [ANGLE_W-1:0]    chain_z   [CORDIC_STAGES+1];

   pipe_ctl_type          ctl0_ff, ctl0_in;
   logic signed [XW-1:0]  x0_ff, x0_in;
   logic signed [XW-1:0]  y0_ff, y0_in;
   logic [ANGLE_W-1:0]    z0_ff, z0_in;
   logic signed [XW-1:0]  a_sc, b_sc;
   logic [ANGLE_W-1:0]    z_raw;
   logic                  accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      a_sc  = XW'(req_first_value) <<< GUARD_BITS;
      b_sc  = XW'(req_second_value) <<< GUARD_BITS;
      z_raw = ANGLE_W'(req_second_value) << ANG_SHIFT;
      ctl0_in.valid   = accept;
      ctl0_in.to_rect = (req_type == REQ_TO_RECT);
      ctl0_in.origin  = (req_first_value == '0) && (req_second_value == '0);
      x0_in = a_sc;
      y0_in = b_sc;
      z0_in = '0;
      if (req_type == REQ_TO_RECT) begin
         y0_in = '0;
         z0_in = z_raw;
         // fold angles beyond a quarter turn
         if ($signed(z_raw) > QUARTER_TURN) begin
            z0_in = z_raw ^ HALF_TURN;
            x0_in = -a_sc;
         end else if ($signed(z_raw) < -QUARTER_TURN) begin
            z0_in = z_raw ^ HALF_TURN;
            x0_in = -a_sc;
         end
      end else if (req_first_value[DW]) begin
         x0_in = -a_sc;
         y0_in = -b_sc;
         z0_in = HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl0_ff.valid <= 1'b0;
      end else begin
         ctl0_ff <= ctl0_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff <= x0_in;
      y0_ff <= y0_in;
      z0_ff <= z0_in;
   end

   assign chain_ctl[0] = ctl0_ff;
   assign chain_x[0]   = x0_ff;
   assign chain_y[0]   = y0_ff;
   assign chain_z[0]   = z0_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      prc_cell #(.XW(XW), .STAGE_INDEX(g)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .in_ctl  (chain_ctl[g]),
         .in_x    (chain_x[g]),
         .in_y    (chain_y[g]),
         .in_z    (chain_z[g]),
         .out_ctl (chain_ctl[g+1]),
         .out_x   (chain_x[g+1]),
         .out_y   (chain_y[g+1]),
         .out_z   (chain_z[g+1])
      );
   end

   prc_post #(.DW(DW), .XW(XW)) u_post (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (chain_ctl[CORDIC_STAGES]),
      .in_x          (chain_x[CORDIC_STAGES]),
      .in_y          (chain_y[CORDIC_STAGES]),
      .in_z          (chain_z[CORDIC_STAGES]),
      .out_strobe    (rsp_strobe),
      .out_first     (rsp_first_result),
      .out_second    (rsp_second_result),
      .out_saturated (rsp_saturated)
   );

   a_chain_to_rsp: assert property (@(posedge clock) disable iff (reset)
      chain_ctl[CORDIC_STAGES].valid |-> ##4 rsp_strobe)
      else $error("transfer left the CORDIC chain but no result followed");

   a_rsp_from_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(chain_ctl[CORDIC_STAGES].valid, 4))
      else $error("result strobe without a matching transfer");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |->
         (rsp_first_result == U_MAX_EXT) || (rsp_first_result == S_MAX_EXT) ||
         (rsp_first_result == S_MIN_EXT) || (rsp_second_result == S_MAX_SEC) ||
         (rsp_second_result == S_MIN_SEC))
      else $error("saturated flag set but no result at a limit");

endmodule

// ----- tb/prc_result_checker.sv -----
// prc_result_checker: watches the request and result channels of the converter,
// predicts each conversion with its own CORDIC model and compares field by field.
// Depends on prc_pkg for the request kind codes.
`timescale 1ns / 1ps

module prc_result_checker
   import prc_pkg::*;
#(
   parameter int DATA_WIDTH    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic                          req_type,
   input  logic signed [DATA_WIDTH:0]    req_first_value,
   input  logic signed [DATA_WIDTH-1:0]  req_second_value,
   input  logic                          rsp_strobe,
   input  logic signed [DATA_WIDTH:0]    rsp_first_result,
   input  logic signed [DATA_WIDTH-1:0]  rsp_second_result,
   input  logic                          rsp_saturated,
   output int                            mismatch_count,
   output int                            outstanding,
   output int                            compared_count,
   output int                            clipped_count
);

   localparam int          ANG_SHIFT = 32 - DATA_WIDTH;
   localparam logic [63:0] GAIN_INV  = 64'd2608131497;
   localparam longint      HALF_TURN_ANG    = 64'sd2147483648;
   localparam longint      QUARTER_TURN_ANG = 64'sd1073741824;

   localparam logic [31:0] ATAN_LUT [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct {
      logic signed [DATA_WIDTH:0]   first;
      logic signed [DATA_WIDTH-1:0] second;
      logic                         sat;
   } coord_pair_type;

   coord_pair_type predicted_pairs[$];

   // drop the CORDIC gain and the guard bits, rounding half away from zero
   function automatic longint remove_gain(longint v);
      logic [63:0] m, hi, lo, t, q;
      m  = (v < 0) ? 64'(-v) : 64'(v);
      hi = (m >> 16) * GAIN_INV;
      lo = (m & 64'hFFFF) * GAIN_INV;
      t  = hi + (lo >> 16);
      q  = (t + (64'd1 << 23)) >> 24;
      return (v < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi, inout logic flag);
      if (v < lo) begin
         flag = 1'b1;
         return lo;
      end
      if (v > hi) begin
         flag = 1'b1;
         return hi;
      end
      return v;
   endfunction

   function automatic coord_pair_type cordic_convert(logic kind,
                                                     logic signed [DATA_WIDTH:0] fv,
                                                     logic signed [DATA_WIDTH-1:0] sv);
      longint         a, b, x, y, z, dx, dy, lim, mag, xo, yo;
      logic [31:0]    ang;
      logic           sat;
      int             i;
      coord_pair_type res;
      a   = fv;
      b   = sv;
      sat = 1'b0;
      if (kind == REQ_TO_POLAR) begin
         x   = a * 256;
         y   = b * 256;
         ang = '0;
         if (a == 0 && b == 0) begin
            res.first  = '0;
            res.second = '0;
         end else begin
            if (x < 0) begin
               x   = -x;
               y   = -y;
               ang = 32'h8000_0000;
            end
            for (i = 0; i < CORDIC_STAGES; i++) begin
               dx = y >>> i;
               dy = x >>> i;
               if (y >= 0) begin
                  x   = x + dx;
                  y   = y - dy;
                  ang = ang + ATAN_LUT[i & 31];
               end else begin
                  x   = x - dx;
                  y   = y + dy;
                  ang = ang - ATAN_LUT[i & 31];
               end
            end
            mag = clamp(remove_gain(x), 0, (longint'(1) << DATA_WIDTH) - 1, sat);
            ang = ang + (32'd1 << (ANG_SHIFT - 1));
            res.first  = mag[DATA_WIDTH:0];
            res.second = ang[31 -: DATA_WIDTH];
         end
      end else begin
         lim = longint'(1) << (DATA_WIDTH - 1);
         x   = a * 256;
         y   = 0;
         z   = b * (longint'(1) << ANG_SHIFT);
         if (z > QUARTER_TURN_ANG) begin
            z = z - HALF_TURN_ANG;
            x = -x;
         end else if (z < -QUARTER_TURN_ANG) begin
            z = z + HALF_TURN_ANG;
            x = -x;
         end
         for (i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - longint'(ATAN_LUT[i & 31]);
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + longint'(ATAN_LUT[i & 31]);
            end
         end
         xo = clamp(remove_gain(x), -lim, lim - 1, sat);
         yo = clamp(remove_gain(y), -lim, lim - 1, sat);
         res.first  = xo[DATA_WIDTH:0];
         res.second = yo[DATA_WIDTH-1:0];
      end
      res.sat = sat;
      return res;
   endfunction

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      compared_count = 0;
      clipped_count  = 0;
   end

   always @(posedge clock) begin
      coord_pair_type want;
      if (rsp_strobe && !reset) begin
         if (predicted_pairs.size() == 0) begin
            mismatch_count++;
            $display("%0t unexpected result: expected none, got %0d %0d %0b", $time,
                     rsp_first_result, rsp_second_result, rsp_saturated);
         end else begin
            want = predicted_pairs.pop_front();
            compared_count++;
            if (want.sat) clipped_count++;
            if (rsp_first_result !== want.first) begin
               mismatch_count++;
               $display("%0t first_result mismatch: expected %0d, got %0d", $time,
                        want.first, rsp_first_result);
            end
            if (rsp_second_result !== want.second) begin
               mismatch_count++;
               $display("%0t second_result mismatch: expected %0d, got %0d", $time,
                        want.second, rsp_second_result);
            end
            if (rsp_saturated !== want.sat) begin
               mismatch_count++;
               $display("%0t saturated mismatch: expected %0b, got %0b", $time,
                        want.sat, rsp_saturated);
            end
         end
      end
      if (!reset && start && !busy)
         predicted_pairs.push_back(cordic_convert(req_type, req_first_value,
                                                  req_second_value));
      outstanding = predicted_pairs.size();
   end

endmodule

// ----- tb/tb_top.sv -----
// tb_top: stimulus and verdict for polar_rectangular_converter_top.
// Drives directed and random coordinate pairs; prc_result_checker does the prediction.
// Depends on prc_pkg, the converter RTL and tb/prc_result_checker.sv.
`timescale 1ns / 1ps

module tb_top
   import prc_pkg::*;
();

   localparam int DATA_WIDTH    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int LATENCY       = CORDIC_STAGES + 5;
   localparam int RANDOM_ITEMS  = 1700;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_type = 1'b0;
   logic signed [DATA_WIDTH:0]   req_first_value = '0;
   logic signed [DATA_WIDTH-1:0] req_second_value = '0;
   logic                         rsp_strobe;
   logic signed [DATA_WIDTH:0]   rsp_first_result;
   logic signed [DATA_WIDTH-1:0] rsp_second_result;
   logic                         rsp_saturated;

   int mismatch_count, outstanding, compared_count, clipped_count;
   int idle_pct;
   int polar_sent, rect_sent;

   always #2 clock = ~clock;

   polar_rectangular_converter_top #(
      .DATA_WIDTH(DATA_WIDTH),
      .CORDIC_STAGES(CORDIC_STAGES)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_first_value(req_first_value),
      .req_second_value(req_second_value),
      .rsp_strobe(rsp_strobe),
      .rsp_first_result(rsp_first_result),
      .rsp_second_result(rsp_second_result),
      .rsp_saturated(rsp_saturated)
   );

   prc_result_checker #(
      .DATA_WIDTH(DATA_WIDTH),
      .CORDIC_STAGES(CORDIC_STAGES)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_first_value(req_first_value),
      .req_second_value(req_second_value),
      .rsp_strobe(rsp_strobe),
      .rsp_first_result(rsp_first_result),
      .rsp_second_result(rsp_second_result),
      .rsp_saturated(rsp_saturated),
      .mismatch_count(mismatch_count),
      .outstanding(outstanding),
      .compared_count(compared_count),
      .clipped_count(clipped_count)
   );

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_pair(req_kind_type kind, int fv, int sv);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start            <= 1'b1;
      req_type         <= kind;
      req_first_value  <= fv[DATA_WIDTH:0];
      req_second_value <= sv[DATA_WIDTH-1:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      if (kind == REQ_TO_POLAR) polar_sent++;
      else rect_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_pair();
      int sel, fv, sv;
      int fv_edges[6] = '{-32768, -1, 0, 1, 32767, 65535};
      int sv_edges[7] = '{-32768, -1, 0, 1, 32767, 16384, -16384};
      req_kind_type kind;
      sel  = $urandom_range(9);
      kind = req_kind_type'($urandom_range(1));
      fv   = int'($urandom_range(98303)) - 32768;
      sv   = int'($urandom_range(65535)) - 32768;
      unique case (sel)
         7: begin
            fv = int'($urandom_range(512)) - 256;
            sv = int'($urandom_range(512)) - 256;
         end
         8: begin
            fv = fv_edges[$urandom_range(5)];
            sv = sv_edges[$urandom_range(6)];
         end
         9: begin
            kind = REQ_TO_RECT;
            sv   = ($urandom_range(1) ? 16384 : -16384) + int'($urandom_range(4)) - 2;
         end
         default: ;
      endcase
      send_pair(kind, fv, sv);
   endtask

   initial begin
      #400_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int n, waited;
      polar_sent = 0;
      rect_sent  = 0;
      idle_pct   = 24;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // origin, axes, 180 degrees, large and out-of-range magnitudes
      send_pair(REQ_TO_POLAR, 0, 0);
      send_pair(REQ_TO_POLAR, 32767, 0);
      send_pair(REQ_TO_POLAR, -32768, 0);
      send_pair(REQ_TO_POLAR, -1, 0);
      send_pair(REQ_TO_POLAR, 1, 0);
      send_pair(REQ_TO_POLAR, 0, 32767);
      send_pair(REQ_TO_POLAR, 0, -32768);
      send_pair(REQ_TO_POLAR, 0, 1);
      send_pair(REQ_TO_POLAR, 65535, 32767);
      send_pair(REQ_TO_POLAR, 65535, -32768);
      send_pair(REQ_TO_POLAR, -32768, -32768);
      send_pair(REQ_TO_POLAR, -256, 256);
      // clipping, negative r, wide angles and quarter-turn boundaries
      send_pair(REQ_TO_RECT, 65535, 0);
      send_pair(REQ_TO_RECT, 65535, 16384);
      send_pair(REQ_TO_RECT, 1000, -32768);
      send_pair(REQ_TO_RECT, 1000, 32767);
      send_pair(REQ_TO_RECT, -32768, 0);
      send_pair(REQ_TO_RECT, -1, 8192);
      send_pair(REQ_TO_RECT, 0, 12345);
      send_pair(REQ_TO_RECT, 20000, 16385);
      send_pair(REQ_TO_RECT, 20000, -16385);
      send_pair(REQ_TO_RECT, 20000, 16384);
      send_pair(REQ_TO_RECT, 46341, 8192);
      send_pair(REQ_TO_RECT, 65535, -24576);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) idle_pct = 56;
         if (n == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
         send_random_pair();
      end
      start <= 1'b0;

      waited = 0;
      while (outstanding != 0 && waited < 20 * LATENCY) begin
         @(negedge clock);
         waited++;
      end
      repeat (2 * LATENCY) @(negedge clock);

      $display("tb: %0d to-polar and %0d to-rect pairs sent, %0d results compared",
               polar_sent, rect_sent, compared_count);
      $display("tb: %0d clipped results, %0d mismatches, %0d results never arrived",
               clipped_count, mismatch_count, outstanding);
      if (mismatch_count == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
